// ===== rtl/zip_entry_metadata_checker_macros.svh =====
// assertion macros for the zip entry metadata checker
// used by the modules that carry concurrent checks; no other dependencies
`ifndef ZIP_ENTRY_METADATA_CHECKER_MACROS_SVH
`define ZIP_ENTRY_METADATA_CHECKER_MACROS_SVH

`ifndef SYNTH

// property that must hold on every clock edge outside reset
`define ZEMC_ASSERT(label, clk, rst, prop) \
  label: assert property (@(posedge clk) disable iff (rst) (prop)) \
    else $error("zemc assertion failed");

// property that must hold in the cycle after a trigger
`define ZEMC_ASSERT_NEXT(label, clk, rst, cond, prop) \
  label: assert property (@(posedge clk) disable iff (rst) (cond) |=> (prop)) \
    else $error("zemc assertion failed");

`else

`define ZEMC_ASSERT(label, clk, rst, prop)

`define ZEMC_ASSERT_NEXT(label, clk, rst, cond, prop)

`endif

`endif

// ===== rtl/zemc_pkg.sv =====
// shared types, codes and constants for the zip entry metadata checker
// no dependencies
`timescale 1ns / 1ps

package zemc_pkg;

  // saturation point of the file and directory tallies
  localparam logic [15:0] ENTRY_COUNT_MAX = 16'd65535;

  // configuration register reset values
  localparam logic [38:0] ENTRY_LIMIT_RESET = 39'd17179869184;
  localparam logic [16:0] RATIO_LIMIT_RESET = 17'd1000;
  localparam logic [40:0] TOTAL_LIMIT_RESET = 41'd68719476736;
  localparam logic [31:0] DIR_OFFSET_RESET  = 32'd0;

  // record field constants
  localparam logic [31:0] FIELD_ALL_ONES  = 32'hffff_ffff;
  localparam logic [15:0] FLAGS_BANNED    = 16'h0001 | 16'h0008 | 16'h0020 | 16'h0040 | 16'h2000;
  localparam logic [15:0] METHOD_STORED   = 16'd0;
  localparam logic [15:0] METHOD_DEFLATE  = 16'd8;
  localparam logic [15:0] MODE_TYPE_MASK  = 16'o170000;
  localparam logic [15:0] MODE_TYPE_DIR   = 16'o040000;
  localparam logic [15:0] MODE_TYPE_REG   = 16'o100000;
  localparam logic [31:0] ATTR_DEV_MASK   = 32'h0000_0440;
  localparam logic [31:0] ATTR_DIR_BIT    = 32'h0000_0010;
  localparam logic [32:0] LOCAL_HDR_MIN   = 33'd30;

  // register indexes on the configuration port
  typedef enum logic [1:0] {
    REG_ENTRY_LIMIT = 2'd0,
    REG_RATIO_LIMIT = 2'd1,
    REG_TOTAL_LIMIT = 2'd2,
    REG_DIR_OFFSET  = 2'd3
  } reg_index_t;

  typedef enum logic {
    CMD_CHECK = 1'b0,
    CMD_CLEAR = 1'b1
  } cmd_t;

  typedef enum logic [3:0] {
    VERDICT_OK           = 4'd0,
    VERDICT_EMPTY_NAME   = 4'd1,
    VERDICT_ZIP64        = 4'd2,
    VERDICT_FLAGS_DISK   = 4'd3,
    VERDICT_METHOD       = 4'd4,
    VERDICT_FILE_TYPE    = 4'd5,
    VERDICT_ATTRIBUTES   = 4'd6,
    VERDICT_DIR_MISMATCH = 4'd7,
    VERDICT_TOO_LARGE    = 4'd8,
    VERDICT_UNBOUNDED    = 4'd9,
    VERDICT_RATIO        = 4'd10,
    VERDICT_TOTAL_PLAIN  = 4'd11,
    VERDICT_TOTAL_PACKED = 4'd12,
    VERDICT_OFFSET       = 4'd13
  } verdict_t;

  typedef struct packed {
    cmd_t        command;
    logic [15:0] record_flags;
    logic [15:0] method_code;
    logic [31:0] packed_size;
    logic [31:0] plain_size;
    logic [31:0] header_offset;
    logic [15:0] start_disk;
    logic [31:0] attributes;
    logic [15:0] name_length;
    logic        ends_in_separator;
  } item_t;

  typedef struct packed {
    verdict_t    verdict;
    logic        is_directory;
    logic [40:0] sum_plain;
    logic [31:0] sum_packed;
    logic [15:0] files_seen;
    logic [15:0] directories_seen;
  } result_t;

  typedef struct packed {
    logic [38:0] entry_limit;
    logic [16:0] ratio_limit;
    logic [40:0] total_limit;
    logic [31:0] dir_offset;
  } cfg_t;

  // classified request handed from the front to the back
  typedef struct packed {
    cmd_t        command;
    verdict_t    verdict;      // first failing state-free check, or ok
    logic        is_dir;
    logic        offset_bad;
    logic [31:0] plain_size;
    logic [31:0] packed_size;
  } cls_t;

endpackage

// ===== rtl/zip_entry_metadata_checker.sv =====
// top level of the zip central-directory entry checker: configuration registers
// and the front, queue and back instances; depends on zemc_pkg and all zemc_* modules
`timescale 1ns / 1ps
//
//  channel   direction  handshake               payload
//  --------  ---------  ----------------------  -------------------------------
//  records   in         push / full             item   (item_t)
//  verdicts  out        pop / empty             result (result_t)
//  config    in/out     psel penable pwrite     paddr[4:3] index, pwdata/prdata 64b
//
//  one record per cycle sustained while full is low; a record is classified as it is
//  pushed, the back end takes it from the queue once the result queue has room, and
//  its result is registered in the result queue before it is on the result port
//  the per-record path is a 32x17 ratio multiply plus compares (front), a 41-bit
//  total add/compare and a 32-bit packed add (back); two-entry queues sit after each
//  sync reset clears totals, tallies and both queues, config returns to reset values
//  full rises only when both the classified queue and the result queue back up

module zip_entry_metadata_checker
  import zemc_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  // record channel
  input  logic        push,
  input  item_t       item,
  output logic        full,
  // result channel
  input  logic        pop,
  output result_t     result,
  output logic        empty,
  // configuration port, registers at byte address 8*index
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [4:0]  paddr,
  input  logic [63:0] pwdata,
  output logic [63:0] prdata,
  output logic        pready
);

  cfg_t       cfg;
  reg_index_t reg_sel;
  logic       cfg_write;
  cls_t       cls_new;
  cls_t       cls_head;
  logic       q_empty;
  logic       q_take;

  // zero-wait-state port; low address bits are ignored
  assign pready    = 1'b1;
  assign reg_sel   = reg_index_t'(paddr[4:3]);
  assign cfg_write = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.entry_limit <= ENTRY_LIMIT_RESET;
      cfg.ratio_limit <= RATIO_LIMIT_RESET;
      cfg.total_limit <= TOTAL_LIMIT_RESET;
      cfg.dir_offset  <= DIR_OFFSET_RESET;
    end else if (cfg_write) begin
      case (reg_sel)
        REG_ENTRY_LIMIT: cfg.entry_limit <= pwdata[38:0];
        REG_RATIO_LIMIT: cfg.ratio_limit <= pwdata[16:0];
        REG_TOTAL_LIMIT: cfg.total_limit <= pwdata[40:0];
        REG_DIR_OFFSET:  cfg.dir_offset  <= pwdata[31:0];
        default:         cfg.dir_offset  <= cfg.dir_offset;
      endcase
    end
  end

  // read-back of the register selected by the address
  always_comb begin
    case (reg_sel)
      REG_ENTRY_LIMIT: prdata = 64'(cfg.entry_limit);
      REG_RATIO_LIMIT: prdata = 64'(cfg.ratio_limit);
      REG_TOTAL_LIMIT: prdata = 64'(cfg.total_limit);
      REG_DIR_OFFSET:  prdata = 64'(cfg.dir_offset);
      default:         prdata = 64'd0;
    endcase
  end

  // state-free checks: name, zip64, flags, method, type, attributes,
  // dir agreement, entry size, unbounded size, ratio and local offset
  zemc_front u_front (
    .item (item),
    .cfg  (cfg),
    .cls  (cls_new)
  );

  // decouples classification from the totals so either side may stall
  zemc_queue u_queue (
    .clk     (clk),
    .rst     (rst),
    .push    (push),
    .wr_data (cls_new),
    .full    (full),
    .pop     (q_take),
    .empty   (q_empty),
    .rd_data (cls_head)
  );

  // running totals, final verdict, commit and result queue
  zemc_back u_back (
    .clk         (clk),
    .rst         (rst),
    .total_limit (cfg.total_limit),
    .head_valid  (!q_empty),
    .head        (cls_head),
    .take        (q_take),
    .result      (result),
    .empty       (empty),
    .pop         (pop)
  );

endmodule

// ===== rtl/zemc_front.sv =====
// front end: classifies one record against the state-free checks
// depends on zemc_pkg
`timescale 1ns / 1ps

module zemc_front
  import zemc_pkg::*;
(
  input  item_t item,
  input  cfg_t  cfg,
  output cls_t  cls
);

  logic [15:0] utype;
  logic        udir;
  logic        ureg;
  logic        dir;
  logic        zip64;
  logic        flags_bad;
  logic        method_bad;
  logic        mismatch;
  logic [48:0] ratio_prod;
  logic [32:0] hdr_end;

  assign utype      = item.attributes[31:16] & MODE_TYPE_MASK;
  assign udir       = (utype == MODE_TYPE_DIR);
  assign ureg       = (utype == MODE_TYPE_REG) || (utype == 16'd0);
  assign dir        = item.ends_in_separator || udir ||
                      ((item.attributes & ATTR_DIR_BIT) != 32'd0);
  assign zip64      = (item.packed_size == FIELD_ALL_ONES) ||
                      (item.plain_size == FIELD_ALL_ONES) ||
                      (item.header_offset == FIELD_ALL_ONES);
  assign flags_bad  = (item.start_disk != 16'd0) ||
                      ((item.record_flags & FLAGS_BANNED) != 16'd0);
  assign method_bad = (item.method_code != METHOD_STORED) &&
                      (item.method_code != METHOD_DEFLATE);
  assign mismatch   = ((utype == MODE_TYPE_REG) && dir) ||
                      (dir && ((item.packed_size != 32'd0) ||
                               (item.plain_size != 32'd0) ||
                               (item.method_code != METHOD_STORED)));
  assign ratio_prod = 49'(item.packed_size) * 49'(cfg.ratio_limit);
  // header at or past the directory start also fails this test
  assign hdr_end    = {1'b0, item.header_offset} + LOCAL_HDR_MIN;

  always_comb begin
    cls.command     = item.command;
    cls.plain_size  = item.plain_size;
    cls.packed_size = item.packed_size;
    cls.offset_bad  = hdr_end > {1'b0, cfg.dir_offset};
    cls.is_dir      = 1'b0;
    cls.verdict     = VERDICT_OK;
    if (item.name_length == 16'd0) begin
      cls.verdict = VERDICT_EMPTY_NAME;
    end else if (zip64) begin
      cls.verdict = VERDICT_ZIP64;
    end else if (flags_bad) begin
      cls.verdict = VERDICT_FLAGS_DISK;
    end else if (method_bad) begin
      cls.verdict = VERDICT_METHOD;
    end else if (!udir && !ureg) begin
      cls.verdict = VERDICT_FILE_TYPE;
    end else if ((item.attributes & ATTR_DEV_MASK) != 32'd0) begin
      cls.verdict = VERDICT_ATTRIBUTES;
    end else begin
      cls.is_dir = dir;
      if (mismatch) begin
        cls.verdict = VERDICT_DIR_MISMATCH;
      end else if (!dir) begin
        if (39'(item.plain_size) > cfg.entry_limit) begin
          cls.verdict = VERDICT_TOO_LARGE;
        end else if ((item.plain_size != 32'd0) && (item.packed_size == 32'd0)) begin
          cls.verdict = VERDICT_UNBOUNDED;
        end else if ((item.packed_size != 32'd0) && (49'(item.plain_size) > ratio_prod)) begin
          cls.verdict = VERDICT_RATIO;
        end
      end
    end
  end

endmodule

// ===== rtl/zemc_queue.sv =====
// two-entry queue of classified requests between front and back
// depends on zemc_pkg
`timescale 1ns / 1ps

module zemc_queue
  import zemc_pkg::*;
(
  input  logic clk,
  input  logic rst,
  input  logic push,
  input  cls_t wr_data,
  output logic full,
  input  logic pop,
  output logic empty,
  output cls_t rd_data
);

  cls_t       mem [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] count;
  logic       push_acc;
  logic       pop_acc;

  assign full     = (count == 2'd2);
  assign empty    = (count == 2'd0);
  assign push_acc = push && !full;
  assign pop_acc  = pop && !empty;
  assign rd_data  = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (push_acc) begin
      mem[wr_ptr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push_acc) begin
        wr_ptr <= ~wr_ptr;
      end
      if (pop_acc) begin
        rd_ptr <= ~rd_ptr;
      end
      case ({push_acc, pop_acc})
        2'b10:   count <= count + 2'd1;
        2'b01:   count <= count - 2'd1;
        default: count <= count;
      endcase
    end
  end

endmodule

// ===== rtl/zemc_back.sv =====
// back end: running totals, final verdict and result queue
// depends on zemc_pkg and the assertion macro header
`timescale 1ns / 1ps
`include "zip_entry_metadata_checker_macros.svh"

module zemc_back
  import zemc_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic [40:0] total_limit,
  input  logic        head_valid,
  input  cls_t        head,
  output logic        take,
  output result_t     result,
  output logic        empty,
  input  logic        pop
);

  // running state
  logic [40:0] plain_total;
  logic [31:0] packed_total;
  logic [15:0] file_tally;
  logic [15:0] directory_tally;

  logic [40:0] plain_total_next;
  logic [31:0] packed_total_next;
  logic [15:0] file_tally_next;
  logic [15:0] directory_tally_next;

  // result queue
  result_t     out_mem [2];
  logic        out_wr;
  logic        out_rd;
  logic [1:0]  out_count;
  logic        out_full;
  logic        out_pop;

  logic [40:0] plain_ext;
  logic [40:0] plain_room;
  logic        plain_bad;
  logic [32:0] packed_sum;
  logic        packed_bad;
  verdict_t    verdict;
  logic        dir_out;
  result_t     res_new;

  assign out_full   = (out_count == 2'd2);
  assign empty      = (out_count == 2'd0);
  assign out_pop    = pop && !empty;
  assign take       = head_valid && !out_full;
  assign result     = out_mem[out_rd];

  assign plain_ext  = 41'(head.plain_size);
  assign plain_room = total_limit - plain_ext;
  assign plain_bad  = (plain_ext > total_limit) || (plain_total > plain_room);
  assign packed_sum = {1'b0, packed_total} + {1'b0, head.packed_size};
  assign packed_bad = packed_sum[32];

  always_comb begin
    plain_total_next     = plain_total;
    packed_total_next    = packed_total;
    file_tally_next      = file_tally;
    directory_tally_next = directory_tally;
    dir_out              = head.is_dir;
    verdict              = VERDICT_OK;
    if (head.command == CMD_CLEAR) begin
      dir_out              = 1'b0;
      plain_total_next     = '0;
      packed_total_next    = '0;
      file_tally_next      = '0;
      directory_tally_next = '0;
    end else begin
      if (head.verdict != VERDICT_OK) begin
        verdict = head.verdict;
      end else if (!head.is_dir && plain_bad) begin
        verdict = VERDICT_TOTAL_PLAIN;
      end else if (!head.is_dir && packed_bad) begin
        verdict = VERDICT_TOTAL_PACKED;
      end else if (head.offset_bad) begin
        verdict = VERDICT_OFFSET;
      end
      if (verdict == VERDICT_OK) begin
        if (head.is_dir) begin
          directory_tally_next = (directory_tally < ENTRY_COUNT_MAX) ?
                                 directory_tally + 16'd1 : ENTRY_COUNT_MAX;
        end else begin
          plain_total_next  = plain_total + plain_ext;
          packed_total_next = packed_sum[31:0];
          file_tally_next   = (file_tally < ENTRY_COUNT_MAX) ?
                              file_tally + 16'd1 : ENTRY_COUNT_MAX;
        end
      end
    end
    res_new.verdict          = verdict;
    res_new.is_directory     = dir_out;
    res_new.sum_plain        = plain_total_next;
    res_new.sum_packed       = packed_total_next;
    res_new.files_seen       = file_tally_next;
    res_new.directories_seen = directory_tally_next;
  end

  always_ff @(posedge clk) begin
    if (take) begin
      out_mem[out_wr] <= res_new;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      plain_total     <= '0;
      packed_total    <= '0;
      file_tally      <= '0;
      directory_tally <= '0;
      out_wr          <= 1'b0;
      out_rd          <= 1'b0;
      out_count       <= 2'd0;
    end else begin
      if (take) begin
        plain_total     <= plain_total_next;
        packed_total    <= packed_total_next;
        file_tally      <= file_tally_next;
        directory_tally <= directory_tally_next;
        out_wr          <= ~out_wr;
      end
      if (out_pop) begin
        out_rd <= ~out_rd;
      end
      case ({take, out_pop})
        2'b10:   out_count <= out_count + 2'd1;
        2'b01:   out_count <= out_count - 2'd1;
        default: out_count <= out_count;
      endcase
    end
  end

  `ZEMC_ASSERT(a_out_count_range, clk, rst, out_count <= 2'd2)
  `ZEMC_ASSERT_NEXT(a_clear_zeroes, clk, rst, take && (head.command == CMD_CLEAR), plain_total == '0 && packed_total == '0 && file_tally == '0 && directory_tally == '0)
  `ZEMC_ASSERT_NEXT(a_fail_holds, clk, rst, take && (head.command == CMD_CHECK) && (verdict != VERDICT_OK), $stable(plain_total) && $stable(packed_total) && $stable(file_tally) && $stable(directory_tally))
  `ZEMC_ASSERT_NEXT(a_dir_no_sizes, clk, rst, take && (head.command == CMD_CHECK) && head.is_dir, $stable(plain_total) && $stable(packed_total) && $stable(file_tally))

endmodule
